[sv/mdsp_pkg.sv]
// Shared types, codes and helpers for the motor deadman supervisor poller.
package mdsp_pkg;

  localparam int AGE_W   = 10;
  localparam int REP_W   = 8;
  localparam int AXIS_W  = 16;
  localparam int VEL_W   = 16;
  localparam int GAIN_W  = 12;
  localparam int SUM_W   = 32;
  localparam int KIND_W  = 3;
  localparam int STEP_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PROD_W  = VEL_W + GAIN_W;
  localparam int DRIVE_SHIFT = 12;

  localparam logic [AGE_W-1:0]  AGE_MAX  = 10'd1023;
  localparam logic [REP_W-1:0]  REP_MAX  = 8'd255;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd4;

  // request types
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_JOY   = 2'd1;
  localparam logic [1:0] REQ_VEL   = 2'd2;
  localparam logic [1:0] REQ_REPLY = 2'd3;

  // serial reply kinds
  localparam logic [1:0] REPLY_OTHER = 2'd0;
  localparam logic [1:0] REPLY_FWID  = 2'd1;
  localparam logic [1:0] REPLY_ENC   = 2'd2;

  // emitted command kinds
  localparam logic [KIND_W-1:0] CMD_DRIVE     = 3'd0;
  localparam logic [KIND_W-1:0] CMD_CONFIGURE = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADMAN_MAX_REPEATS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_MAX_AGE         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOY_TIMEOUT         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_TIMEOUT        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_GAIN       = 3'd4;

  typedef struct packed {
    logic [REP_W-1:0]  deadman_max_repeats;
    logic [AGE_W-1:0]  cmd_max_age;
    logic [AGE_W-1:0]  joy_timeout;
    logic [AGE_W-1:0]  link_timeout;
    logic [GAIN_W-1:0] velocity_gain;
  } cfg_t;

  // one pending result, classified by the front end
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VEL_W-1:0] vel;
    logic                    enc_valid;
    logic [SUM_W-1:0]        total;
  } job_t;

  function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
    age_up = (a < AGE_MAX) ? a + 1'b1 : AGE_MAX;
  endfunction

endpackage

[sv/mdsp_front.sv]
// Front end: accepts events, keeps the supervisor state and classifies results.
module mdsp_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mdsp_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic                                in_deadman_button,
  input  logic signed [mdsp_pkg::AXIS_W-1:0]  in_axis_x,
  input  logic signed [mdsp_pkg::AXIS_W-1:0]  in_axis_y,
  input  logic signed [mdsp_pkg::AXIS_W-1:0]  in_axis_z,
  input  logic signed [mdsp_pkg::VEL_W-1:0]   in_velocity_cmd,
  input  logic [mdsp_pkg::AGE_W-1:0]          in_cmd_age_at_arrival,
  input  logic [1:0]                          in_reply_kind,
  input  logic signed [15:0]                  in_encoder_delta,
  output logic                                push_valid,
  input  logic                                push_ready,
  output mdsp_pkg::job_t                      push_job
);

  logic                                init_r, init_nxt;
  logic                                joy_seen_r, joy_seen_nxt;
  logic                                deadman_ok_r, deadman_ok_nxt;
  logic                                cmd_active_r, cmd_active_nxt;
  logic [mdsp_pkg::REP_W-1:0]          repeat_count_r, repeat_count_nxt;
  logic [mdsp_pkg::AXIS_W-1:0]         prev_x_r, prev_x_nxt;
  logic [mdsp_pkg::AXIS_W-1:0]         prev_y_r, prev_y_nxt;
  logic [mdsp_pkg::AXIS_W-1:0]         prev_z_r, prev_z_nxt;
  logic [mdsp_pkg::VEL_W-1:0]          held_vel_r, held_vel_nxt;
  logic [mdsp_pkg::AGE_W-1:0]          cmd_age_r, cmd_age_nxt;
  logic [mdsp_pkg::AGE_W-1:0]          joy_age_r, joy_age_nxt;
  logic [mdsp_pkg::AGE_W-1:0]          link_age_r, link_age_nxt;
  logic [mdsp_pkg::STEP_W-1:0]         poll_step_r, poll_step_nxt;
  logic [mdsp_pkg::SUM_W-1:0]          enc_sum_r, enc_sum_nxt;

  logic                                accept;
  logic                                emit;
  logic [mdsp_pkg::STEP_W-1:0]         step_inc;
  logic [mdsp_pkg::REP_W-1:0]          rep_cnt;
  logic signed [mdsp_pkg::VEL_W-1:0]   vel;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign push_valid = accept && emit;

  always_comb begin
    init_nxt         = init_r;
    joy_seen_nxt     = joy_seen_r;
    deadman_ok_nxt   = deadman_ok_r;
    cmd_active_nxt   = cmd_active_r;
    repeat_count_nxt = repeat_count_r;
    prev_x_nxt       = prev_x_r;
    prev_y_nxt       = prev_y_r;
    prev_z_nxt       = prev_z_r;
    held_vel_nxt     = held_vel_r;
    cmd_age_nxt      = cmd_age_r;
    joy_age_nxt      = joy_age_r;
    link_age_nxt     = link_age_r;
    poll_step_nxt    = poll_step_r;
    enc_sum_nxt      = enc_sum_r;
    emit             = 1'b0;
    step_inc         = poll_step_r + 1'b1;
    rep_cnt          = repeat_count_r;
    vel              = '0;
    push_job         = '0;

    case (in_req_type)
      mdsp_pkg::REQ_TICK: begin
        joy_age_nxt  = mdsp_pkg::age_up(joy_age_r);
        cmd_age_nxt  = mdsp_pkg::age_up(cmd_age_r);
        link_age_nxt = mdsp_pkg::age_up(link_age_r);
        if (init_r) begin
          emit = 1'b1;
          if (deadman_ok_r && cmd_active_r) begin
            if (joy_age_nxt > cfg.joy_timeout) begin
              deadman_ok_nxt = 1'b0;
            end else if (cmd_age_nxt > cfg.cmd_max_age) begin
              cmd_active_nxt = 1'b0;
            end else begin
              vel = held_vel_r;
            end
          end
          if (link_age_nxt > cfg.link_timeout) begin
            init_nxt = 1'b0;
          end
          if (poll_step_r inside {[3'd1:mdsp_pkg::STEP_LAST]}) begin
            push_job.kind = poll_step_r;
          end else begin
            push_job.kind = mdsp_pkg::CMD_DRIVE;
          end
          // drive value only on step zero; stray steps drive zero
          push_job.vel = (poll_step_r == '0) ? vel : '0;
          if (step_inc > mdsp_pkg::STEP_LAST) begin
            poll_step_nxt      = '0;
            push_job.enc_valid = 1'b1;
            push_job.total     = enc_sum_r;
          end else begin
            poll_step_nxt = step_inc;
          end
        end
      end
      mdsp_pkg::REQ_JOY: begin
        if (!joy_seen_r) begin
          joy_seen_nxt = 1'b1;
        end else begin
          deadman_ok_nxt = in_deadman_button;
          if (in_axis_x == prev_x_r && in_axis_y == prev_y_r && in_axis_z == prev_z_r) begin
            rep_cnt = (repeat_count_r < mdsp_pkg::REP_MAX) ? repeat_count_r + 1'b1
                                                            : mdsp_pkg::REP_MAX;
          end else begin
            rep_cnt = '0;
          end
          repeat_count_nxt = rep_cnt;
          if (rep_cnt > cfg.deadman_max_repeats) begin
            deadman_ok_nxt = 1'b0;
          end
        end
        prev_x_nxt  = in_axis_x;
        prev_y_nxt  = in_axis_y;
        prev_z_nxt  = in_axis_z;
        joy_age_nxt = '0;
      end
      mdsp_pkg::REQ_VEL: begin
        held_vel_nxt   = in_velocity_cmd;
        cmd_age_nxt    = in_cmd_age_at_arrival;
        cmd_active_nxt = 1'b1;
      end
      default: begin
        link_age_nxt = '0;
        case (in_reply_kind)
          mdsp_pkg::REPLY_FWID: begin
            init_nxt      = 1'b1;
            emit          = 1'b1;
            push_job.kind = mdsp_pkg::CMD_CONFIGURE;
          end
          mdsp_pkg::REPLY_ENC: begin
            enc_sum_nxt = enc_sum_r + {{(mdsp_pkg::SUM_W-16){in_encoder_delta[15]}},
                                       in_encoder_delta};
          end
          default: begin
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r         <= 1'b0;
      joy_seen_r     <= 1'b0;
      deadman_ok_r   <= 1'b0;
      cmd_active_r   <= 1'b0;
      repeat_count_r <= '0;
      prev_x_r       <= '0;
      prev_y_r       <= '0;
      prev_z_r       <= '0;
      held_vel_r     <= '0;
      cmd_age_r      <= '0;
      joy_age_r      <= '0;
      link_age_r     <= '0;
      poll_step_r    <= '0;
      enc_sum_r      <= '0;
    end else if (accept) begin
      init_r         <= init_nxt;
      joy_seen_r     <= joy_seen_nxt;
      deadman_ok_r   <= deadman_ok_nxt;
      cmd_active_r   <= cmd_active_nxt;
      repeat_count_r <= repeat_count_nxt;
      prev_x_r       <= prev_x_nxt;
      prev_y_r       <= prev_y_nxt;
      prev_z_r       <= prev_z_nxt;
      held_vel_r     <= held_vel_nxt;
      cmd_age_r      <= cmd_age_nxt;
      joy_age_r      <= joy_age_nxt;
      link_age_r     <= link_age_nxt;
      poll_step_r    <= poll_step_nxt;
      enc_sum_r      <= enc_sum_nxt;
    end
  end

endmodule

[sv/mdsp_queue.sv]
// Small register queue of classified results between front and back end.
module mdsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mdsp_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mdsp_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mdsp_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/mdsp_back.sv]
// Back end: scales the drive value through a multiply stage and holds the result.
module mdsp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mdsp_pkg::GAIN_W-1:0]         velocity_gain,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  mdsp_pkg::job_t                      job,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mdsp_pkg::KIND_W-1:0]         out_cmd_kind,
  output logic signed [15:0]                  out_drive_value,
  output logic                                out_encoder_valid,
  output logic signed [mdsp_pkg::SUM_W-1:0]   out_encoder_total
);

  logic                                s1_valid_r;
  logic [mdsp_pkg::PROD_W-1:0]         s1_prod_r;
  logic                                s1_neg_r;
  logic [mdsp_pkg::KIND_W-1:0]         s1_kind_r;
  logic                                s1_ev_r;
  logic [mdsp_pkg::SUM_W-1:0]          s1_total_r;

  logic                                out_valid_r;
  logic [mdsp_pkg::KIND_W-1:0]         out_kind_r;
  logic [15:0]                         out_drive_r;
  logic                                out_ev_r;
  logic [mdsp_pkg::SUM_W-1:0]          out_total_r;

  logic                                out_load, s1_free, take;
  logic [mdsp_pkg::VEL_W-1:0]          mag;
  logic [15:0]                         quot;
  logic [15:0]                         drive_nxt;

  assign out_load  = !out_valid_r || out_ready;
  assign s1_free   = !s1_valid_r || out_load;
  assign job_ready = s1_free;
  assign take      = job_valid && s1_free;

  // magnitude of -32768 fits as unsigned 0x8000
  assign mag       = job.vel[mdsp_pkg::VEL_W-1] ? (~job.vel + 1'b1) : job.vel;
  assign quot      = s1_prod_r[mdsp_pkg::DRIVE_SHIFT +: 16];
  assign drive_nxt = s1_neg_r ? (~quot + 1'b1) : quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_r <= job_valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_prod_r  <= mag * velocity_gain;
      s1_neg_r   <= job.vel[mdsp_pkg::VEL_W-1];
      s1_kind_r  <= job.kind;
      s1_ev_r    <= job.enc_valid;
      s1_total_r <= job.total;
    end
    if (out_load && s1_valid_r) begin
      out_kind_r  <= s1_kind_r;
      out_drive_r <= drive_nxt;
      out_ev_r    <= s1_ev_r;
      out_total_r <= s1_total_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cmd_kind      = out_kind_r;
  assign out_drive_value   = out_drive_r;
  assign out_encoder_valid = out_ev_r;
  assign out_encoder_total = out_total_r;

endmodule

[sv/motor_deadman_supervisor_poller_unit.sv]
// Top level of the motor deadman supervisor poller: registers, front, queue and back end.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    event type and event fields
//   out_     output     out_valid / out_ready  command kind, drive, encoder report
//   cfg_     input      cfg_valid / cfg_ready  register index, write data
//
// One event is accepted per cycle; the front end updates all supervisor state in the
// cycle it accepts the event. A result passes through the queue and the gain multiplier
// stage, then sits in the output register until taken. Synchronous active-low reset
// clears supervisor, queue and pipeline control state, but not stored payloads, and
// loads the register defaults. Input stalls only when the result queue is full;
// cfg_ready is always high.
module motor_deadman_supervisor_poller_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic                                in_deadman_button,
  input  logic signed [15:0]                  in_axis_x,
  input  logic signed [15:0]                  in_axis_y,
  input  logic signed [15:0]                  in_axis_z,
  input  logic signed [15:0]                  in_velocity_cmd,
  input  logic [9:0]                          in_cmd_age_at_arrival,
  input  logic [1:0]                          in_reply_kind,
  input  logic signed [15:0]                  in_encoder_delta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_cmd_kind,
  output logic signed [15:0]                  out_drive_value,
  output logic                                out_encoder_valid,
  output logic signed [31:0]                  out_encoder_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mdsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mdsp_pkg::cfg_t cfg_r;
  mdsp_pkg::job_t push_job, pop_job;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadman_max_repeats <= 8'd30;
      cfg_r.cmd_max_age         <= 10'd10;
      cfg_r.joy_timeout         <= 10'd20;
      cfg_r.link_timeout        <= 10'd100;
      cfg_r.velocity_gain       <= 12'd500;
    end else if (cfg_valid) begin
      case (cfg_index)
        mdsp_pkg::CFG_DEADMAN_MAX_REPEATS: cfg_r.deadman_max_repeats <= cfg_data[7:0];
        mdsp_pkg::CFG_CMD_MAX_AGE:         cfg_r.cmd_max_age         <= cfg_data[9:0];
        mdsp_pkg::CFG_JOY_TIMEOUT:         cfg_r.joy_timeout         <= cfg_data[9:0];
        mdsp_pkg::CFG_LINK_TIMEOUT:        cfg_r.link_timeout        <= cfg_data[9:0];
        mdsp_pkg::CFG_VELOCITY_GAIN:       cfg_r.velocity_gain       <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  mdsp_front u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_deadman_button     (in_deadman_button),
    .in_axis_x             (in_axis_x),
    .in_axis_y             (in_axis_y),
    .in_axis_z             (in_axis_z),
    .in_velocity_cmd       (in_velocity_cmd),
    .in_cmd_age_at_arrival (in_cmd_age_at_arrival),
    .in_reply_kind         (in_reply_kind),
    .in_encoder_delta      (in_encoder_delta),
    .push_valid            (push_valid),
    .push_ready            (push_ready),
    .push_job              (push_job)
  );

  mdsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  mdsp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .velocity_gain     (cfg_r.velocity_gain),
    .job_valid         (pop_valid),
    .job_ready         (pop_ready),
    .job               (pop_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmd_kind      (out_cmd_kind),
    .out_drive_value   (out_drive_value),
    .out_encoder_valid (out_encoder_valid),
    .out_encoder_total (out_encoder_total)
  );

endmodule
